/* rtl/llo_pkg.sv */
// ----------------------------------------------------------------------------
// llo_pkg
// Shared types and codes for the LIFO lock order checker.
// ----------------------------------------------------------------------------
`default_nettype none

package llo_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int ID_WIDTH_DEF    = 32;

   localparam int LOCK_ID_W = 32;
   localparam int STEP_W    = 16;
   localparam int STATUS_W  = 3;
   localparam int OPCODE_W  = 2;

   localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_END     = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] STS_WRONG_RELEASE = 3'd1;
   localparam logic [STATUS_W-1:0] STS_DOUBLE_ACQ    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_ACQUIRED  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_DANGLING      = 3'd4;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW      = 3'd5;

   localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [LOCK_ID_W-1:0] lock_id;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [STEP_W-1:0]   error_step;
      logic                log_done;
   } rsp_item_type;

endpackage

`default_nettype wire

/* rtl/lifo_lock_order_checker_unit.sv */
// ----------------------------------------------------------------------------
// lifo_lock_order_checker_unit
// Checks that locks are released in reverse order of acquisition.
// ----------------------------------------------------------------------------
//   channel   ports                          direction   content
//   req       req_valid req_stall req_item   in          opcode, lock id
//   rsp       rsp_valid rsp_stall rsp_item   out         status, step, done
//
// Acquire/release with no error held and a non-empty stack scan the held entries
// from the bottom up to a match, one stack memory read per cycle; other items skip it.
// One item in flight; the result sits in an output register while the next
// item is taken. Reset clears control state; the stack memory is not cleared
// (only entries below the count are read). A stalled result holds the block
// at its final cycle until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_lock_order_checker_unit #(
   parameter int STACK_DEPTH = llo_pkg::STACK_DEPTH_DEF,
   parameter int ID_WIDTH    = llo_pkg::ID_WIDTH_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  llo_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output llo_pkg::rsp_item_type rsp_item
);

   import llo_pkg::*;

   localparam int KEY_W = (ID_WIDTH < LOCK_ID_W) ? ID_WIDTH : LOCK_ID_W;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_FIN    = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic                found_ff, found_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STATUS_W-1:0] sticky_ff, sticky_in;
   logic [STEP_W-1:0]   evt_ff, evt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   logic [KEY_W-1:0]    stack_mem [STACK_DEPTH];
   logic [KEY_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;

   logic accept, slot_free, fin_fire, match, more;
   logic [CNT_W-1:0]    ptr_ext, pos_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign fin_fire  = (state_ff == ST_FIN) && slot_free;
   assign match     = (rd_data_ff == key_ff);
   assign ptr_ext   = CNT_W'(ptr_ff);
   assign pos_next  = ptr_ext + CNT_W'(1);
   assign more      = (pos_next < cnt_ff);
   assign wr_addr   = cnt_ff[IDX_W-1:0];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      ptr_in       = ptr_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      sticky_in    = sticky_ff;
      evt_in       = evt_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_item.opcode;
               key_in   = req_item.lock_id[KEY_W-1:0];
               ptr_in   = '0;
               found_in = 1'b0;
               if ((req_item.opcode == OP_ACQUIRE || req_item.opcode == OP_RELEASE) &&
                   sticky_ff == STS_OK && cnt_ff != '0) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SEARCH: begin
            if (match) begin
               found_in = 1'b1;
               state_in = ST_FIN;
            end else if (more) begin
               ptr_in  = pos_next[IDX_W-1:0];
               rd_addr = pos_next[IDX_W-1:0];
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               state_in             = ST_IDLE;
               rsp_valid_in         = 1'b1;
               rsp_item_in.log_done = 1'b0;
               case (op_ff) inside
                  OP_ACQUIRE, OP_RELEASE: begin
                     if (sticky_ff == STS_OK) begin
                        if (evt_ff != STEP_MAX) begin
                           evt_in = evt_ff + STEP_W'(1);
                        end
                        if (op_ff == OP_ACQUIRE) begin
                           if (found_ff) begin
                              sticky_in = STS_DOUBLE_ACQ;
                           end else if (cnt_ff >= CNT_W'(STACK_DEPTH)) begin
                              sticky_in = STS_OVERFLOW;
                           end else begin
                              wr_en  = 1'b1;
                              cnt_in = cnt_ff + CNT_W'(1);
                           end
                        end else begin
                           if (!found_ff) begin
                              sticky_in = STS_NOT_ACQUIRED;
                           end else if (pos_next != cnt_ff) begin
                              sticky_in = STS_WRONG_RELEASE;
                           end else begin
                              cnt_in = cnt_ff - CNT_W'(1);
                           end
                        end
                     end
                     rsp_item_in.status     = sticky_in;
                     rsp_item_in.error_step = evt_in;
                  end
                  OP_END: begin
                     rsp_item_in.status     = (sticky_ff == STS_OK && cnt_ff != '0) ?
                                              STS_DANGLING : sticky_ff;
                     rsp_item_in.error_step = evt_ff;
                     rsp_item_in.log_done   = 1'b1;
                     cnt_in                 = '0;
                     sticky_in              = STS_OK;
                     evt_in                 = '0;
                  end
                  default: begin
                     rsp_item_in.status     = sticky_ff;
                     rsp_item_in.error_step = evt_ff;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= key_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      ptr_ff      <= ptr_in;
      found_ff    <= found_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sticky_ff    <= STS_OK;
         evt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sticky_ff    <= sticky_in;
         evt_ff       <= evt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (ptr_ext < cnt_ff))
      else $error("search pointer past stack top");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && op_ff == OP_END) |=>
         (cnt_ff == '0 && sticky_ff == STS_OK && evt_ff == '0 && rsp_item_ff.log_done))
      else $error("end item did not clear state");

   a_error_freezes_stack: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && sticky_ff != STS_OK && op_ff != OP_END) |=> $stable(cnt_ff))
      else $error("stack changed while an error is held");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lifo_lock_order_checker_unit. A scoreboard class
// predicts the status, error step and done flag of every accepted item
// from its own model of the lock stack. Directed logs cover each error kind
// but overflow, the extreme lock ids and the unused opcode. Random logs are
// mostly well-nested with injected errors, forced overflow and dangling locks.
// The request side idles and the result side stalls at random.
// ----------------------------------------------------------------------------

module tb;
   import llo_pkg::*;

   localparam int STACK_DEPTH = llo_pkg::STACK_DEPTH_DEF;
   localparam int ITEM_TARGET = 600;
   localparam int CYCLE_LIMIT = 2000000;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int STALL_NONE  = 0;
   localparam int STALL_RAND  = 1;
   localparam int STALL_BURST = 2;

   class lock_order_scoreboard;
      logic [LOCK_ID_W-1:0] held [STACK_DEPTH];
      int                   depth;
      logic [STATUS_W-1:0]  first_error;
      logic [STEP_W-1:0]    events;
      rsp_item_type         expected_q [$];
      int                   errors;
      int                   accepted_items;
      int                   results;
      int                   logs_closed;
      int                   end_tally [8];
      logic [STEP_W-1:0]    max_step;

      function void clear_log();
         depth       = 0;
         first_error = STS_OK;
         events      = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(req_item_type it);
         rsp_item_type exp_item;
         int           pos;
         bit           done;
         pos  = -1;
         done = 1'b0;
         accepted_items++;
         for (int i = 0; i < depth; i++) begin
            if (pos < 0 && held[i] == it.lock_id) pos = i;
         end
         case (it.opcode)
            OP_ACQUIRE, OP_RELEASE: begin
               if (first_error == STS_OK) begin
                  if (events != STEP_MAX) events++;
                  if (it.opcode == OP_ACQUIRE) begin
                     if (pos >= 0) first_error = STS_DOUBLE_ACQ;
                     else if (depth >= STACK_DEPTH) first_error = STS_OVERFLOW;
                     else begin
                        held[depth] = it.lock_id;
                        depth++;
                     end
                  end else begin
                     if (pos < 0) first_error = STS_NOT_ACQUIRED;
                     else if (pos + 1 != depth) first_error = STS_WRONG_RELEASE;
                     else depth--;
                  end
               end
            end
            OP_END: begin
               if (first_error == STS_OK && depth != 0) first_error = STS_DANGLING;
               done = 1'b1;
            end
            default: ;
         endcase
         exp_item.status     = first_error;
         exp_item.error_step = events;
         exp_item.log_done   = done;
         expected_q.insert(expected_q.size(), exp_item);
         if (events > max_step) max_step = events;
         if (done) begin
            end_tally[int'(first_error)]++;
            logs_closed++;
            clear_log();
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp_item;
         results++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result status %0d step %0d done %0b", $time,
                     got.status, got.error_step, got.log_done);
            errors++;
            return;
         end
         exp_item = expected_q.pop_front();
         if (got.status !== exp_item.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_item.status, got.status);
            errors++;
         end
         if (got.error_step !== exp_item.error_step) begin
            $display("%0t: error_step expected %0d actual %0d", $time,
                     exp_item.error_step, got.error_step);
            errors++;
         end
         if (got.log_done !== exp_item.log_done) begin
            $display("%0t: log_done expected %0b actual %0b", $time,
                     exp_item.log_done, got.log_done);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   lock_order_scoreboard sb;
   int                   cycles;
   int                   burst_left;
   int                   stall_mode;
   int                   mode_left;
   int                   hold_left;
   bit                   hold_val;

   lifo_lock_order_checker_unit #(
      .STACK_DEPTH (STACK_DEPTH),
      .ID_WIDTH    (ID_WIDTH_DEF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("lifo_lock_order_checker_unit verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_item);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_item);
   end

   // receiver backpressure: segments of no stall, random stall, long stall runs
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_BURST);
         mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
         STALL_RAND: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_BURST: begin
            if (hold_left == 0) begin
               hold_left = $urandom_range(1, 24);
               hold_val  = ~hold_val;
            end
            hold_left--;
            rsp_stall <= hold_val;
         end
         default: rsp_stall <= 1'b0;
      endcase
   end

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [LOCK_ID_W-1:0] id);
      req_item_type it;
      int           gap;
      it.opcode  = op;
      it.lock_id = id;
      gap        = 0;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic run_log(input int forced_depth);
      logic [LOCK_ID_W-1:0] pool [24];
      logic [LOCK_ID_W-1:0] held_q [$];
      logic [LOCK_ID_W-1:0] id;
      int                   goal;
      int                   steps;
      int                   roll;
      bit                   forced;
      bit                   taken;
      for (int i = 0; i < 24; i++) begin
         case ($urandom_range(0, 3))
            0: pool[i] = i;
            1: pool[i] = 32'hFFFF_FFFF - i;
            default: pool[i] = $urandom;
         endcase
      end
      forced = (forced_depth > 0);
      roll   = $urandom_range(0, 99);
      if (forced) goal = forced_depth;
      else if (roll < 15) goal = $urandom_range(10, STACK_DEPTH);
      else if (roll < 20) goal = STACK_DEPTH + 1;
      else goal = $urandom_range(1, 6);
      steps = forced ? goal : $urandom_range(2, 2 * goal + 8);
      for (int k = 0; k < steps; k++) begin
         roll = forced ? 99 : $urandom_range(0, 99);
         if (roll < 3) begin
            send_item(OP_UNUSED, $urandom);
         end else if (roll < 7) begin
            case ($urandom_range(0, 2))
               0: if (held_q.size() > 0)
                     send_item(OP_ACQUIRE, held_q[$urandom_range(0, held_q.size() - 1)]);
               1: send_item(OP_RELEASE, $urandom);
               default: if (held_q.size() >= 2)
                     send_item(OP_RELEASE, held_q[$urandom_range(0, held_q.size() - 2)]);
            endcase
         end else if (held_q.size() == 0 ||
                      (held_q.size() < goal && (forced || $urandom_range(0, 99) < 65))) begin
            id    = pool[$urandom_range(0, 23)];
            taken = 1'b0;
            foreach (held_q[j]) if (held_q[j] == id) taken = 1'b1;
            if (taken) id = $urandom;
            send_item(OP_ACQUIRE, id);
            held_q.insert(held_q.size(), id);
         end else begin
            send_item(OP_RELEASE, held_q.pop_back());
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         while (held_q.size() > 0) send_item(OP_RELEASE, held_q.pop_back());
      end
      send_item(OP_END, $urandom);
   endtask

   initial begin
      int start_count;
      sb         = new;
      sb.clear_log();
      cycles     = 0;
      burst_left = 0;
      mode_left  = 0;
      hold_left  = 0;
      hold_val   = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      rsp_stall  = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // clean nesting with extreme ids and an unused opcode inside
      send_item(OP_ACQUIRE, 32'h0000_0000);
      send_item(OP_ACQUIRE, 32'hFFFF_FFFF);
      send_item(OP_UNUSED, 32'h5A5A_A5A5);
      send_item(OP_RELEASE, 32'hFFFF_FFFF);
      send_item(OP_RELEASE, 32'h0000_0000);
      send_item(OP_END, 32'hFFFF_FFFF);
      // double acquire, then an ignored release
      send_item(OP_ACQUIRE, 32'h1);
      send_item(OP_ACQUIRE, 32'h1);
      send_item(OP_RELEASE, 32'h1);
      send_item(OP_END, 32'h0);
      // release of a lock never taken
      send_item(OP_RELEASE, 32'h7);
      send_item(OP_END, 32'h0);
      // out of order release; dangling not reported over it
      send_item(OP_ACQUIRE, 32'h2);
      send_item(OP_ACQUIRE, 32'h3);
      send_item(OP_RELEASE, 32'h2);
      send_item(OP_END, 32'h0);
      // dangling lock
      send_item(OP_ACQUIRE, 32'h8000_0004);
      send_item(OP_END, 32'h0);
      // empty log, unused opcode on a fresh log
      send_item(OP_END, 32'h0);
      send_item(OP_UNUSED, 32'hFFFF_FFFF);

      run_log(STACK_DEPTH + 1);
      start_count = sb.accepted_items;
      while (sb.accepted_items - start_count < ITEM_TARGET) run_log(0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4 * STACK_DEPTH) @(posedge clock);

      $display("%0d results checked over %0d logs, highest step %0d", sb.results,
               sb.logs_closed, sb.max_step);
      $display("log endings: ok %0d, wrong release %0d, double acquire %0d, %s %0d, %s %0d, %s %0d",
               sb.end_tally[STS_OK], sb.end_tally[STS_WRONG_RELEASE],
               sb.end_tally[STS_DOUBLE_ACQ], "not acquired", sb.end_tally[STS_NOT_ACQUIRED],
               "dangling", sb.end_tally[STS_DANGLING], "overflow",
               sb.end_tally[STS_OVERFLOW]);
      if (sb.errors == 0) begin
         $display("lifo_lock_order_checker_unit verification clean");
      end else begin
         $display("lifo_lock_order_checker_unit verification failed");
      end
      $finish;
   end

endmodule
